// ===== rtl/wcs_pkg.sv =====
// Shared types and constants for the WebAssembly custom-section stripper.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package wcs_pkg;

   // Default parameter values
   localparam int HEADER_BYTES_DEF = 8;
   localparam int LENGTH_WIDTH_DEF = 32;

   // LEB128 length encoding
   localparam int        LEB_DATA_BITS = 7;
   localparam int        LEB_CONT_BIT  = 7;
   localparam int        LEN_CNT_WIDTH = 3;
   localparam logic [LEN_CNT_WIDTH-1:0] MAX_LEN_BYTES = 3'd5;

   // Section id of a custom section
   localparam logic [7:0] CUSTOM_SECTION_ID = 8'h00;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_TYPE    = 5'b00010,
      PH_LENGTH  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_BAD     = 5'b10000
   } phase_type;

   // One input byte
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_type;

   // One result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      logic       end_of_module;
      logic       corrupt;
      logic       found_custom;
   } rsp_type;

endpackage

// ===== rtl/wcs_core.sv =====
// Section parser: running parse state and the per-byte keep/drop decision.
// Depends on wcs_pkg.

module wcs_core #(
   parameter int HEADER_BYTES = wcs_pkg::HEADER_BYTES_DEF,
   parameter int LENGTH_WIDTH = wcs_pkg::LENGTH_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  wcs_pkg::req_type req,
   output wcs_pkg::rsp_type rsp
);

   localparam int HdrCntWidth = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam logic [HdrCntWidth-1:0] HdrLast = HdrCntWidth'(HEADER_BYTES - 1);
   localparam int ExtWidth = LENGTH_WIDTH + 4 * wcs_pkg::LEB_DATA_BITS;
   localparam logic [LENGTH_WIDTH-1:0] LenAllOnes = '1;

   wcs_pkg::phase_type              phase_ff, phase_in, step_phase;
   logic [HdrCntWidth-1:0]          hdr_cnt_ff, hdr_cnt_in;
   logic [LENGTH_WIDTH-1:0]         len_acc_ff, len_acc_in;
   logic [wcs_pkg::LEN_CNT_WIDTH-1:0] len_cnt_ff, len_cnt_in, len_cnt_inc;
   logic [LENGTH_WIDTH-1:0]         pay_left_ff, pay_left_in;
   logic                            dropping_ff, dropping_in;
   logic                            seen_ff, seen_in;

   logic [ExtWidth-1:0]             leb_ext;
   logic [ExtWidth-1:0]             leb_shifted;
   logic [LENGTH_WIDTH-1:0]         len_sum;
   logic [LENGTH_WIDTH-1:0]         pay_dec;
   logic                            keep;
   logic                            bad;
   logic                            drop_now;
   logic                            seen_step;

   // Place the seven data bits of this length byte at their LEB128 position
   assign leb_ext = ExtWidth'(req.in_byte[wcs_pkg::LEB_DATA_BITS-1:0]);
   always_comb begin
      case (len_cnt_ff)
         3'd0:    leb_shifted = leb_ext;
         3'd1:    leb_shifted = leb_ext << wcs_pkg::LEB_DATA_BITS;
         3'd2:    leb_shifted = leb_ext << (2 * wcs_pkg::LEB_DATA_BITS);
         3'd3:    leb_shifted = leb_ext << (3 * wcs_pkg::LEB_DATA_BITS);
         3'd4:    leb_shifted = leb_ext << (4 * wcs_pkg::LEB_DATA_BITS);
         default: leb_shifted = '0;
      endcase
   end

   assign len_sum     = len_acc_ff + leb_shifted[LENGTH_WIDTH-1:0];
   assign len_cnt_inc = len_cnt_ff + 3'd1;
   assign pay_dec     = pay_left_ff - LENGTH_WIDTH'(1);
   assign drop_now    = (req.in_byte == wcs_pkg::CUSTOM_SECTION_ID);

   // Custom section seen so far, including this byte
   assign seen_step = seen_ff || ((phase_ff == wcs_pkg::PH_TYPE) && drop_now);

   // Advance the parse state by one byte
   always_comb begin
      step_phase  = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      len_acc_in  = len_acc_ff;
      len_cnt_in  = len_cnt_ff;
      pay_left_in = pay_left_ff;
      dropping_in = dropping_ff;
      seen_in     = seen_ff;
      keep        = 1'b0;
      bad         = 1'b0;

      case (phase_ff)
         wcs_pkg::PH_HEADER: begin
            keep = 1'b1;
            if (hdr_cnt_ff == HdrLast) begin
               step_phase = wcs_pkg::PH_TYPE;
               hdr_cnt_in = '0;
            end else begin
               hdr_cnt_in = hdr_cnt_ff + HdrCntWidth'(1);
               bad        = req.is_last;
            end
         end
         wcs_pkg::PH_TYPE: begin
            dropping_in = drop_now;
            if (drop_now) begin
               seen_in = 1'b1;
            end
            len_acc_in = '0;
            len_cnt_in = '0;
            step_phase = wcs_pkg::PH_LENGTH;
            bad        = req.is_last;
            keep       = !drop_now;
         end
         wcs_pkg::PH_LENGTH: begin
            len_acc_in = len_sum;
            len_cnt_in = len_cnt_inc;
            if (req.in_byte[wcs_pkg::LEB_CONT_BIT]) begin
               bad = (len_cnt_inc >= wcs_pkg::MAX_LEN_BYTES) || req.is_last;
            end else if (len_sum == LenAllOnes) begin
               bad = 1'b1;
            end else if (len_sum == '0) begin
               step_phase = wcs_pkg::PH_TYPE;
            end else if (req.is_last) begin
               bad = 1'b1;
            end else begin
               pay_left_in = len_sum;
               step_phase  = wcs_pkg::PH_PAYLOAD;
            end
            keep = !dropping_ff;
         end
         wcs_pkg::PH_PAYLOAD: begin
            pay_left_in = pay_dec;
            if (pay_dec == '0) begin
               step_phase = wcs_pkg::PH_TYPE;
            end else begin
               bad = req.is_last;
            end
            keep = !dropping_ff;
         end
         default: begin
         end
      endcase

      // Corruption is sticky until the end of the module
      if (bad) begin
         step_phase = wcs_pkg::PH_BAD;
      end
      if (step_phase == wcs_pkg::PH_BAD) begin
         keep = 1'b0;
      end

      phase_in = step_phase;
      // Return to the header phase after the final byte
      if (req.is_last) begin
         phase_in    = wcs_pkg::PH_HEADER;
         hdr_cnt_in  = '0;
         len_acc_in  = '0;
         len_cnt_in  = '0;
         pay_left_in = '0;
         dropping_in = 1'b0;
         seen_in     = 1'b0;
      end
   end

   // Build the result for this byte
   always_comb begin
      rsp.out_byte      = req.in_byte;
      rsp.keep          = keep;
      rsp.end_of_module = req.is_last;
      rsp.corrupt       = req.is_last && (step_phase == wcs_pkg::PH_BAD);
      rsp.found_custom  = req.is_last && seen_step;
   end

   // Hold state except when a byte moves through
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wcs_pkg::PH_HEADER;
         hdr_cnt_ff  <= '0;
         len_acc_ff  <= '0;
         len_cnt_ff  <= '0;
         pay_left_ff <= '0;
         dropping_ff <= 1'b0;
         seen_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         len_acc_ff  <= len_acc_in;
         len_cnt_ff  <= len_cnt_in;
         pay_left_ff <= pay_left_in;
         dropping_ff <= dropping_in;
         seen_ff     <= seen_in;
      end
   end

`ifndef SYNTHESIS
   // A payload phase always has bytes still due
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wcs_pkg::PH_PAYLOAD) |-> (pay_left_ff != '0))
      else $error("payload phase with nothing left");

   // The final byte returns the parser to a clean header phase
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step_en && req.is_last) |=> (phase_ff == wcs_pkg::PH_HEADER) && !seen_ff
                                   && !dropping_ff)
      else $error("parser not restarted after final byte");

   // Length phase never holds more than the allowed number of length bytes
   a_len_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wcs_pkg::PH_LENGTH) |-> (len_cnt_ff < wcs_pkg::MAX_LEN_BYTES))
      else $error("length byte count out of range");
`endif

endmodule

// ===== rtl/wasm_custom_section_stripper.sv =====
// Top level of the WebAssembly custom-section stripper: input register,
// output register and handshake. Depends on wcs_pkg and wcs_core.
//
// Usage:
//   Bytes of a module image enter on the req_ channel (req_data.in_byte,
//   req_data.is_last marks the final byte). One result per byte leaves on
//   the rsp_ channel, in order: the byte, a keep flag, and on the final
//   byte the corrupt and found_custom summary flags.
//   A transfer happens on a channel when its valid and ready are both high.
//   Path: a byte accepted on req_ sits in the input register, then moves
//   to the result register and is presented on rsp_.
//   Throughput: one byte per cycle while rsp_ready stays high; the parse
//   state is updated as a byte moves between the two registers, so bytes
//   follow back to back.
//   Stall: when rsp_ready is low the result register holds; one more byte is
//   held in the input register, after which req_ready drops.
//   Reset (synchronous, active high) empties both registers and puts the
//   parser in the header phase; after the final byte of a module the parser
//   also returns to the header phase on its own.

module wasm_custom_section_stripper #(
   parameter int HEADER_BYTES = wcs_pkg::HEADER_BYTES_DEF,
   parameter int LENGTH_WIDTH = wcs_pkg::LENGTH_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wcs_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   wcs_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   wcs_pkg::rsp_type rsp_data_ff;
   wcs_pkg::rsp_type step_rsp;
   logic             advance;
   logic             req_xfer;

   // Move a byte from the input register to the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   wcs_core #(
      .HEADER_BYTES (HEADER_BYTES),
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .rsp     (step_rsp)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Never overwrite a held input byte
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!in_valid_ff || advance))
      else $error("input register overwritten");

   // A byte leaving the input register shows up as a result
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced byte lost");

   // Both registers are empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_valid_ff))
      else $error("registers not empty after reset");
`endif

endmodule

// ===== tb/sv/wasm_custom_section_stripper_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for wasm_custom_section_stripper: a directed table of module
// images, then random well-formed and broken modules, checked by a byte-level predictor.
// Depends on wcs_pkg and the stripper RTL.

module wasm_custom_section_stripper_test;

   localparam int HDR_N        = wcs_pkg::HEADER_BYTES_DEF;
   localparam int LEN_W        = wcs_pkg::LENGTH_WIDTH_DEF;
   localparam int DIR_N        = 26;
   localparam int RANDOM_ITEMS = 1950;
   localparam int RESET_CYCLES = 8;
   localparam int TAIL_CYCLES  = 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_MAX   = 10;

   // One directed row: input byte, last flag, and the typed-in result where there is one
   typedef struct packed {
      logic [7:0] b;
      logic       last;
      logic       typed;
      logic       keep;
      logic       corrupt;
      logic       found;
   } dir_row_type;

   typedef struct packed {
      wcs_pkg::req_type req;
      logic             typed;
      wcs_pkg::rsp_type want;
   } stim_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   wcs_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   wcs_pkg::rsp_type rsp_data;

   // Predictor state
   wcs_pkg::phase_type parse_ph    = wcs_pkg::PH_HEADER;
   int                 hdr_cnt     = 0;
   logic [LEN_W-1:0]   len_acc     = '0;
   int                 len_cnt     = 0;
   logic [LEN_W-1:0]   pay_left    = '0;
   logic               in_custom   = 1'b0;
   logic               custom_seen = 1'b0;

   stim_row_type     stim_q[$];
   logic [7:0]       mod_bytes[$];
   wcs_pkg::rsp_type due_results[$];

   int               sent_cnt     = 0;
   int               result_cnt   = 0;
   int               mismatches   = 0;
   int               quiet_cycles = 0;
   int               drained_load = 0;
   int               cur_load;
   logic             took_req;
   logic             took_rsp;
   wcs_pkg::rsp_type predicted;
   wcs_pkg::rsp_type due;

   // Load phases: none, sender idle, receiver stall, both
   int send_idle_pct[4] = '{0, 80, 0, 20};
   int stall_pct[4]     = '{0, 0, 80, 20};

   dir_row_type directed_rows[DIR_N] = '{
      // truncated inside the header: byte dropped, module corrupt
      '{8'hff, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
      // header passes through kept
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h61, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h73, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h6d, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      // custom section of length zero: type and length dropped
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      // kept section whose length decodes to all ones
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h0f, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      // everything after corruption is dropped
      '{8'h55, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1},
      // module ending right after the header is clean
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h61, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h73, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h6d, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}
   };

   wasm_custom_section_stripper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advance the parse state by one byte and return the result it should produce
   function automatic wcs_pkg::rsp_type strip_byte(input wcs_pkg::req_type r);
      wcs_pkg::rsp_type res;
      logic             bad;
      logic             keep_b;
      logic [63:0]      sum;
      int               shift;
      bad    = 1'b0;
      keep_b = 1'b0;
      case (parse_ph)
         wcs_pkg::PH_HEADER: begin
            keep_b = 1'b1;
            if (hdr_cnt + 1 >= HDR_N) begin
               parse_ph = wcs_pkg::PH_TYPE;
               hdr_cnt  = 0;
            end else begin
               hdr_cnt = hdr_cnt + 1;
               if (r.is_last) bad = 1'b1;
            end
         end
         wcs_pkg::PH_TYPE: begin
            in_custom = (r.in_byte == wcs_pkg::CUSTOM_SECTION_ID);
            if (in_custom) custom_seen = 1'b1;
            len_acc  = '0;
            len_cnt  = 0;
            parse_ph = wcs_pkg::PH_LENGTH;
            if (r.is_last) bad = 1'b1;
            keep_b = !in_custom;
         end
         wcs_pkg::PH_LENGTH: begin
            // accumulate seven bits per byte, wrapping at the length width
            shift   = wcs_pkg::LEB_DATA_BITS * (len_cnt % wcs_pkg::MAX_LEN_BYTES);
            sum     = 64'(len_acc) +
                      (64'(r.in_byte[wcs_pkg::LEB_DATA_BITS-1:0]) << shift);
            len_acc = sum[LEN_W-1:0];
            len_cnt = (len_cnt + 1) & 7;
            if (r.in_byte[wcs_pkg::LEB_CONT_BIT]) begin
               if (len_cnt >= wcs_pkg::MAX_LEN_BYTES || r.is_last) bad = 1'b1;
            end else if (len_acc == '1) begin
               bad = 1'b1;
            end else if (len_acc == '0) begin
               parse_ph = wcs_pkg::PH_TYPE;
            end else if (r.is_last) begin
               bad = 1'b1;
            end else begin
               pay_left = len_acc;
               parse_ph = wcs_pkg::PH_PAYLOAD;
            end
            keep_b = !in_custom;
         end
         wcs_pkg::PH_PAYLOAD: begin
            pay_left = pay_left - 1'b1;
            if (pay_left == '0) parse_ph = wcs_pkg::PH_TYPE;
            else if (r.is_last) bad = 1'b1;
            keep_b = !in_custom;
         end
         default: ;
      endcase
      if (bad) parse_ph = wcs_pkg::PH_BAD;
      if (parse_ph == wcs_pkg::PH_BAD) keep_b = 1'b0;
      res.out_byte      = r.in_byte;
      res.keep          = keep_b;
      res.end_of_module = r.is_last;
      res.corrupt       = r.is_last && (parse_ph == wcs_pkg::PH_BAD);
      res.found_custom  = r.is_last && custom_seen;
      // drop all state at the end of a module
      if (r.is_last) begin
         parse_ph    = wcs_pkg::PH_HEADER;
         hdr_cnt     = 0;
         len_acc     = '0;
         len_cnt     = 0;
         pay_left    = '0;
         in_custom   = 1'b0;
         custom_seen = 1'b0;
      end
      return res;
   endfunction

   // Append one byte to the module being built
   function automatic void add_byte(input logic [7:0] b);
      mod_bytes.insert(mod_bytes.size(), b);
   endfunction

   // Append one well-formed section, sometimes with a padded length encoding
   function automatic void add_section();
      int unsigned len_val;
      int          ngrp;
      logic [7:0]  sid;
      sid     = ($urandom_range(99) < 35) ? wcs_pkg::CUSTOM_SECTION_ID
                                          : 8'($urandom_range(255, 1));
      len_val = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
      ngrp    = 1;
      while (ngrp < 5 && (len_val >> (7 * ngrp)) != 0) ngrp++;
      if ($urandom_range(4) == 0) ngrp = ngrp + $urandom_range(4, 1);
      if (ngrp > 5) ngrp = 5;
      add_byte(sid);
      for (int i = 0; i < ngrp; i++)
         add_byte({1'(i < ngrp - 1), 7'(len_val >> (7 * i))});
      repeat (len_val) add_byte(8'($urandom));
   endfunction

   // Move the built module into the stimulus, ending it at the given byte
   function automatic void ship_module(input int cut);
      stim_row_type row;
      for (int i = 0; i <= cut; i++) begin
         row.req.in_byte = mod_bytes[i];
         row.req.is_last = (i == cut);
         row.typed       = 1'b0;
         row.want        = '0;
         stim_q.insert(stim_q.size(), row);
      end
      mod_bytes.delete();
   endfunction

   function automatic int load_phase(input int idx);
      int p;
      if (idx < DIR_N) return 0;
      p = (idx - DIR_N) * 4 / (stim_q.size() - DIR_N);
      return (p > 3) ? 3 : p;
   endfunction

   // Build the stimulus, release reset, and wait for the last result
   initial begin
      stim_row_type row;
      int           kind;
      foreach (directed_rows[i]) begin
         row.req.in_byte = directed_rows[i].b;
         row.req.is_last = directed_rows[i].last;
         row.typed       = directed_rows[i].typed;
         row.want        = '{directed_rows[i].b, directed_rows[i].keep, directed_rows[i].last,
                             directed_rows[i].corrupt, directed_rows[i].found};
         stim_q.insert(stim_q.size(), row);
      end
      while (stim_q.size() < DIR_N + RANDOM_ITEMS) begin
         kind = $urandom_range(99);
         repeat (HDR_N) add_byte(8'($urandom));
         if (kind < 60) begin
            // well-formed module
            repeat ($urandom_range(4)) add_section();
            ship_module(mod_bytes.size() - 1);
         end else if (kind < 75) begin
            // well-formed module cut short anywhere
            repeat ($urandom_range(4, 1)) add_section();
            ship_module($urandom_range(mod_bytes.size() - 1));
         end else if (kind < 83) begin
            // length running past five bytes
            repeat ($urandom_range(1)) add_section();
            add_byte(8'($urandom));
            repeat (5) add_byte({1'b1, 7'($urandom)});
            repeat ($urandom_range(3)) add_byte(8'($urandom));
            ship_module(mod_bytes.size() - 1);
         end else if (kind < 88) begin
            // length of all ones
            repeat ($urandom_range(1)) add_section();
            add_byte(8'($urandom));
            repeat (4) add_byte(8'hff);
            add_byte(8'h0f);
            repeat ($urandom_range(3)) add_byte(8'($urandom));
            ship_module(mod_bytes.size() - 1);
         end else if (kind < 95) begin
            // five-byte length with wrap, payload cut short
            add_byte(8'($urandom));
            repeat (4) add_byte({1'b1, 7'($urandom)});
            add_byte({1'b0, 7'($urandom)});
            repeat ($urandom_range(5, 1)) add_byte(8'($urandom));
            ship_module(mod_bytes.size() - 1);
         end else begin
            // noise after the header
            repeat ($urandom_range(30, 1)) add_byte(8'($urandom));
            ship_module(mod_bytes.size() - 1);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (!(sent_cnt == stim_q.size() && due_results.size() == 0)) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // predict the result of an input transfer
         took_req = req_valid && req_ready;
         if (took_req) begin
            predicted = strip_byte(req_data);
            if (stim_q[sent_cnt].typed) predicted = stim_q[sent_cnt].want;
            due_results.insert(due_results.size(), predicted);
            sent_cnt++;
         end

         // check a result transfer against the oldest prediction
         took_rsp = rsp_valid && rsp_ready;
         if (took_rsp) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result %0d unexpected: byte %h keep %b eom %b corrupt %b custom %b",
                           result_cnt, rsp_data.out_byte, rsp_data.keep,
                           rsp_data.end_of_module, rsp_data.corrupt, rsp_data.found_custom);
            end else begin
               due = due_results.pop_front();
               if (rsp_data.out_byte !== due.out_byte || rsp_data.keep !== due.keep ||
                   rsp_data.end_of_module !== due.end_of_module ||
                   rsp_data.corrupt !== due.corrupt ||
                   rsp_data.found_custom !== due.found_custom) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("result %0d: expected byte %h keep %b eom %b corrupt %b ",
                              result_cnt, due.out_byte, due.keep, due.end_of_module,
                              due.corrupt,
                              "custom %b, got byte %h keep %b eom %b corrupt %b custom %b",
                              due.found_custom, rsp_data.out_byte,
                              rsp_data.keep, rsp_data.end_of_module, rsp_data.corrupt,
                              rsp_data.found_custom);
               end
            end
            result_cnt++;
         end
         quiet_cycles = (took_req || took_rsp) ? 0 : quiet_cycles + 1;

         // at a new load phase, hold off the sender until every result is back
         cur_load = load_phase(sent_cnt);
         if (cur_load > drained_load && due_results.size() == 0) drained_load = cur_load;

         // hold a pending transfer; otherwise offer the next byte or idle
         if (!(req_valid && !took_req)) begin
            if (sent_cnt < stim_q.size() && cur_load == drained_load &&
                $urandom_range(99) >= send_idle_pct[cur_load]) begin
               req_valid <= 1'b1;
               req_data  <= stim_q[sent_cnt].req;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct[cur_load]);
      end
   end

endmodule
